FILE: rtl/rttwpj_pkg.sv
// Shared constants and codes for the RTT window percentile and jitter block.
`timescale 1ns / 1ps

package rttwpj_pkg;

  // Fixed field widths of the ports
  localparam int RTT_W     = 24;
  localparam int COUNT_W   = 8;
  localparam int WLEN_W    = 8;
  localparam int PCT_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  // Percent scale used to turn the percentile into a rank
  localparam int PCT_SCALE = 100;

  // floor(x / 100) == (x * RANK_RECIP) >> RANK_SHIFT for every x below 199728,
  // which covers percentile * n at any supported window depth
  localparam int RANK_SHIFT   = 24;
  localparam int RANK_RECIP   = 167773;
  localparam int RANK_RECIP_W = 18;

  // Opcodes of an input beat
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERCENTILE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_DEFAULT = 2'd2;

  // Register reset values
  localparam logic [WLEN_W-1:0] WLEN_RST = 8'd100;
  localparam logic [PCT_W-1:0]  PCT_RST  = 7'd95;
  localparam logic [RTT_W-1:0]  DFLT_RST = 24'd50000;

endpackage

FILE: rtl/rtt_window_percentile_jitter.sv
// Sliding RTT window with percentile, median and mean absolute deviation on query.
`timescale 1ns / 1ps

// A push beat (opcode 0) writes one sample into the sample RAM; the oldest
// sample leaves the window once window_len samples are held.
// A query beat (opcode 1) ranks the n held samples and returns one result beat.
// With an empty window a query goes straight to the finish step, and with a
// single sample the jitter scan and divide are skipped. Otherwise every
// sample is tried as a rank candidate and counted against the whole window
// through the single read port of the sample RAM, the tail rank comes from
// one reciprocal multiply, and the jitter mean uses a bit-serial divider.
// The input is not ready during a query; a finished result waits in the
// output register, the last step holds while a previous result is still
// unaccepted, and the input side reopens as soon as the result is loaded
// there.
module rtt_window_percentile_jitter #(
  parameter int WINDOW_DEPTH = 128,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [rttwpj_pkg::CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [rttwpj_pkg::CFG_DAT_W-1:0]   cfg_wdata_i,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               opcode_i,
  input  logic [rttwpj_pkg::RTT_W-1:0]       rtt_sample_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rttwpj_pkg::RTT_W-1:0]       tail_rtt_o,
  output logic [rttwpj_pkg::RTT_W-1:0]       median_rtt_o,
  output logic [rttwpj_pkg::RTT_W-1:0]       jitter_o,
  output logic [rttwpj_pkg::COUNT_W-1:0]     sample_count_o,
  output logic                               window_empty_o
);

  import rttwpj_pkg::*;

  localparam int PTR_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int DVD_W = SAMPLE_BITS + CNT_W;
  localparam int DVS_W = (CNT_W > 7) ? CNT_W : 7;
  localparam int DC_W  = $clog2(DVD_W + 1);
  localparam int PRD_W = PCT_W + CNT_W;
  localparam int RP_W  = PRD_W + RANK_RECIP_W;
  localparam int RQ_W  = RP_W - RANK_SHIFT;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TDIV  = 4'd1;
  localparam logic [3:0] S_CRD   = 4'd2;
  localparam logic [3:0] S_CWAIT = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_CEVAL = 4'd5;
  localparam logic [3:0] S_JSCAN = 4'd6;
  localparam logic [3:0] S_JDIV  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  // window length clamped to 1..WINDOW_DEPTH
  function automatic logic [CNT_W-1:0] eff_len(input logic [WLEN_W-1:0] wl);
    logic [CNT_W-1:0] r;
    if (wl == '0) begin
      r = CNT_W'(1);
    end else if (32'(wl) > WINDOW_DEPTH) begin
      r = CNT_W'(WINDOW_DEPTH);
    end else begin
      r = CNT_W'(wl);
    end
    return r;
  endfunction

  // ring slot one step older
  function automatic logic [PTR_W-1:0] prev_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == '0) begin
      r = PTR_W'(WINDOW_DEPTH - 1);
    end else begin
      r = p - 1'b1;
    end
    return r;
  endfunction

  logic [3:0]             state_q, state_d;
  logic [WLEN_W-1:0]      wlen_q, wlen_d;
  logic [PCT_W-1:0]       pct_q, pct_d;
  logic [RTT_W-1:0]       dflt_q, dflt_d;
  logic [PTR_W-1:0]       write_slot_q, write_slot_d;
  logic [CNT_W-1:0]       held_count_q, held_count_d;
  logic [SAMPLE_BITS-1:0] last_jitter_q, last_jitter_d;

  logic [CNT_W-1:0]       n_q, n_d;
  logic                   empty_q, empty_d;
  logic [PTR_W-1:0]       cand_ptr_q, cand_ptr_d;
  logic [CNT_W-1:0]       cand_cnt_q, cand_cnt_d;
  logic [PTR_W-1:0]       scan_ptr_q, scan_ptr_d;
  logic [CNT_W-1:0]       iss_cnt_q, iss_cnt_d;
  logic [CNT_W-1:0]       acc_cnt_q, acc_cnt_d;
  logic                   rd_vld_q, rd_vld_d;
  logic [SAMPLE_BITS-1:0] cand_q, cand_d;
  logic [CNT_W-1:0]       lt_q, lt_d;
  logic [CNT_W-1:0]       le_q, le_d;
  logic [CNT_W-1:0]       tail_rank_q, tail_rank_d;
  logic [SAMPLE_BITS-1:0] tail_val_q, tail_val_d;
  logic [SAMPLE_BITS-1:0] med_val_q, med_val_d;
  logic [DVD_W-1:0]       sum_q, sum_d;

  logic [DVD_W-1:0]       dq_q, dq_d;
  logic [DVS_W-1:0]       rem_q, rem_d;
  logic [DVS_W-1:0]       dvs_q, dvs_d;
  logic [DC_W-1:0]        div_cnt_q, div_cnt_d;

  logic                   out_valid_q, out_valid_d;
  logic [RTT_W-1:0]       tail_out_q, tail_out_d;
  logic [RTT_W-1:0]       med_out_q, med_out_d;
  logic [RTT_W-1:0]       jit_out_q, jit_out_d;
  logic [COUNT_W-1:0]     cnt_out_q, cnt_out_d;
  logic                   empty_out_q, empty_out_d;

  logic [SAMPLE_BITS-1:0] mem [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] rdata_q;
  logic [PTR_W-1:0]       rd_addr;
  logic                   mem_we;
  logic [SAMPLE_BITS-1:0] wr_data;

  logic                   in_fire;
  logic [PTR_W-1:0]       start_slot;
  logic [CNT_W-1:0]       med_rank;
  logic [CNT_W-1:0]       eff_now;
  logic                   issue;
  logic [SAMPLE_BITS-1:0] abs_diff;

  // tail rank: percentile * n divided by 100 through the reciprocal
  logic [RP_W-1:0]        rank_prod;
  logic [RQ_W-1:0]        rank_quo;

  // divider step: shift one dividend bit into the remainder, try subtract
  logic [DVS_W:0]         rem_sh;
  logic                   div_ge;
  logic [DVS_W:0]         rem_sub;
  logic [DVD_W-1:0]       dq_step;
  logic [DVS_W-1:0]       rem_step;
  logic                   div_last;

  assign rank_prod = RP_W'(dq_q[PRD_W-1:0]) * RP_W'(RANK_RECIP);
  assign rank_quo  = rank_prod[RP_W-1:RANK_SHIFT];

  assign rem_sh   = {rem_q, dq_q[DVD_W-1]};
  assign div_ge   = rem_sh >= {1'b0, dvs_q};
  assign rem_sub  = rem_sh - {1'b0, dvs_q};
  assign rem_step = div_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
  assign dq_step  = {dq_q[DVD_W-2:0], div_ge};
  assign div_last = div_cnt_q == DC_W'(DVD_W - 1);

  assign in_ready_o = state_q == S_IDLE;
  assign in_fire    = in_valid_i && in_ready_o;
  assign start_slot = prev_slot(write_slot_q);
  assign med_rank   = n_q >> 1;
  assign eff_now    = eff_len(wlen_q);
  assign wr_data    = SAMPLE_BITS'(rtt_sample_i);
  assign mem_we     = in_fire && (opcode_i == OP_PUSH);
  assign issue      = ((state_q == S_SCAN) || (state_q == S_JSCAN)) && (iss_cnt_q != n_q);
  assign rd_addr    = (state_q == S_CRD) ? cand_ptr_q : scan_ptr_q;
  assign abs_diff   = (rdata_q >= med_val_q) ? (rdata_q - med_val_q) : (med_val_q - rdata_q);

  // sample RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[write_slot_q] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  // sequencer and datapath next state
  always_comb begin
    logic [CNT_W-1:0] held_tmp;
    logic [CNT_W-1:0] eff_new;
    logic [DVD_W-1:0] q_last;
    logic [DVD_W-1:0] n_m1;

    state_d       = state_q;
    wlen_d        = wlen_q;
    pct_d         = pct_q;
    dflt_d        = dflt_q;
    write_slot_d  = write_slot_q;
    held_count_d  = held_count_q;
    last_jitter_d = last_jitter_q;
    n_d           = n_q;
    empty_d       = empty_q;
    cand_ptr_d    = cand_ptr_q;
    cand_cnt_d    = cand_cnt_q;
    scan_ptr_d    = scan_ptr_q;
    iss_cnt_d     = iss_cnt_q;
    acc_cnt_d     = acc_cnt_q;
    rd_vld_d      = issue;
    cand_d        = cand_q;
    lt_d          = lt_q;
    le_d          = le_q;
    tail_rank_d   = tail_rank_q;
    tail_val_d    = tail_val_q;
    med_val_d     = med_val_q;
    sum_d         = sum_q;
    dq_d          = dq_q;
    rem_d         = rem_q;
    dvs_d         = dvs_q;
    div_cnt_d     = div_cnt_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    tail_out_d    = tail_out_q;
    med_out_d     = med_out_q;
    jit_out_d     = jit_out_q;
    cnt_out_d     = cnt_out_q;
    empty_out_d   = empty_out_q;
    held_tmp      = held_count_q;
    eff_new       = eff_len(cfg_wdata_i[WLEN_W-1:0]);
    q_last        = dq_step;
    n_m1          = DVD_W'(n_q) - DVD_W'(1);

    // read-port issue shared by both scans
    if (issue) begin
      scan_ptr_d = prev_slot(scan_ptr_q);
      iss_cnt_d  = iss_cnt_q + CNT_W'(1);
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (opcode_i == OP_PUSH) begin
            write_slot_d = (32'(write_slot_q) + 1 >= WINDOW_DEPTH) ? '0
                                                                  : write_slot_q + 1'b1;
            held_tmp     = (held_count_q < eff_now) ? held_count_q + CNT_W'(1) : eff_now;
          end else begin
            n_d = held_count_q;
            if (held_count_q == '0) begin
              empty_d = 1'b1;
              state_d = S_FIN;
            end else begin
              empty_d = 1'b0;
              dq_d    = DVD_W'(pct_q) * DVD_W'(held_count_q);
              state_d = S_TDIV;
            end
          end
        end
      end

      // tail rank = percentile * n / 100 by reciprocal multiply, clamped to n - 1
      S_TDIV: begin
        if (DVD_W'(rank_quo) > n_m1) begin
          tail_rank_d = n_q - CNT_W'(1);
        end else begin
          tail_rank_d = rank_quo[CNT_W-1:0];
        end
        cand_ptr_d = start_slot;
        cand_cnt_d = '0;
        state_d    = S_CRD;
      end

      S_CRD: begin
        state_d = S_CWAIT;
      end

      S_CWAIT: begin
        cand_d     = rdata_q;
        scan_ptr_d = start_slot;
        iss_cnt_d  = '0;
        acc_cnt_d  = '0;
        lt_d       = '0;
        le_d       = '0;
        state_d    = S_SCAN;
      end

      // count window samples below and not above the candidate
      S_SCAN: begin
        if (rd_vld_q) begin
          if (rdata_q < cand_q) begin
            lt_d = lt_q + CNT_W'(1);
            le_d = le_q + CNT_W'(1);
          end else if (rdata_q == cand_q) begin
            le_d = le_q + CNT_W'(1);
          end
          acc_cnt_d = acc_cnt_q + CNT_W'(1);
          if (acc_cnt_q + CNT_W'(1) == n_q) begin
            state_d = S_CEVAL;
          end
        end
      end

      // candidate holds a rank when lt <= rank < le
      S_CEVAL: begin
        if ((lt_q <= tail_rank_q) && (tail_rank_q < le_q)) begin
          tail_val_d = cand_q;
        end
        if ((lt_q <= med_rank) && (med_rank < le_q)) begin
          med_val_d = cand_q;
        end
        cand_ptr_d = prev_slot(cand_ptr_q);
        cand_cnt_d = cand_cnt_q + CNT_W'(1);
        if (cand_cnt_q + CNT_W'(1) == n_q) begin
          if (n_q > CNT_W'(1)) begin
            scan_ptr_d = start_slot;
            iss_cnt_d  = '0;
            acc_cnt_d  = '0;
            sum_d      = '0;
            state_d    = S_JSCAN;
          end else begin
            state_d = S_FIN;
          end
        end else begin
          state_d = S_CRD;
        end
      end

      // sum of absolute deviations from the median
      S_JSCAN: begin
        if (rd_vld_q) begin
          sum_d     = sum_q + DVD_W'(abs_diff);
          acc_cnt_d = acc_cnt_q + CNT_W'(1);
          if (acc_cnt_q + CNT_W'(1) == n_q) begin
            dq_d      = sum_q + DVD_W'(abs_diff);
            rem_d     = '0;
            dvs_d     = DVS_W'(n_q);
            div_cnt_d = '0;
            state_d   = S_JDIV;
          end
        end
      end

      S_JDIV: begin
        dq_d      = dq_step;
        rem_d     = rem_step;
        div_cnt_d = div_cnt_q + DC_W'(1);
        if (div_last) begin
          last_jitter_d = q_last[SAMPLE_BITS-1:0];
          state_d       = S_FIN;
        end
      end

      // load the output register once it is free
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          tail_out_d  = empty_q ? dflt_q : RTT_W'(tail_val_q);
          med_out_d   = empty_q ? dflt_q : RTT_W'(med_val_q);
          jit_out_d   = RTT_W'(last_jitter_q);
          cnt_out_d   = COUNT_W'(n_q);
          empty_out_d = empty_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // register writes; a shorter window keeps only the newest samples
    held_count_d = held_tmp;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_WINDOW_LEN: begin
          wlen_d = cfg_wdata_i[WLEN_W-1:0];
          if (held_tmp > eff_new) begin
            held_count_d = eff_new;
          end
        end
        CFG_PERCENTILE: begin
          pct_d = cfg_wdata_i[PCT_W-1:0];
        end
        CFG_EMPTY_DEFAULT: begin
          dflt_d = cfg_wdata_i[RTT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      wlen_q        <= WLEN_RST;
      pct_q         <= PCT_RST;
      dflt_q        <= DFLT_RST;
      write_slot_q  <= '0;
      held_count_q  <= '0;
      last_jitter_q <= '0;
      rd_vld_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      wlen_q        <= wlen_d;
      pct_q         <= pct_d;
      dflt_q        <= dflt_d;
      write_slot_q  <= write_slot_d;
      held_count_q  <= held_count_d;
      last_jitter_q <= last_jitter_d;
      rd_vld_q      <= rd_vld_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload and work registers
  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    empty_q     <= empty_d;
    cand_ptr_q  <= cand_ptr_d;
    cand_cnt_q  <= cand_cnt_d;
    scan_ptr_q  <= scan_ptr_d;
    iss_cnt_q   <= iss_cnt_d;
    acc_cnt_q   <= acc_cnt_d;
    cand_q      <= cand_d;
    lt_q        <= lt_d;
    le_q        <= le_d;
    tail_rank_q <= tail_rank_d;
    tail_val_q  <= tail_val_d;
    med_val_q   <= med_val_d;
    sum_q       <= sum_d;
    dq_q        <= dq_d;
    rem_q       <= rem_d;
    dvs_q       <= dvs_d;
    div_cnt_q   <= div_cnt_d;
    tail_out_q  <= tail_out_d;
    med_out_q   <= med_out_d;
    jit_out_q   <= jit_out_d;
    cnt_out_q   <= cnt_out_d;
    empty_out_q <= empty_out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign tail_rtt_o     = tail_out_q;
  assign median_rtt_o   = med_out_q;
  assign jitter_o       = jit_out_q;
  assign sample_count_o = cnt_out_q;
  assign window_empty_o = empty_out_q;

`ifndef SYNTHESIS
  // window never holds more samples than the RAM
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_count_q <= CNT_W'(WINDOW_DEPTH))
    else $error("held count beyond window depth");

  // a new result beat only comes from the finish step
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FIN))
    else $error("result raised outside finish step");

  // below-count never passes the not-above count during a scan
  a_rank_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) || (state_q == S_CEVAL) |-> lt_q <= le_q)
    else $error("rank counters out of order");
`endif

endmodule

FILE: tb/sv/tb_rtt_window_percentile_jitter.sv
// Testbench for the sliding RTT window percentile, median and jitter block.
`timescale 1ns / 1ps

module tb_rtt_window_percentile_jitter;
  import rttwpj_pkg::*;

  localparam int WINDOW_DEPTH = 128;
  localparam int SAMPLE_BITS  = 24;
  // Register index that decodes to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // Cycles to let a push settle before touching registers
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [RTT_W-1:0]   tail;
    logic [RTT_W-1:0]   median;
    logic [RTT_W-1:0]   jitter;
    logic [COUNT_W-1:0] count;
    logic               empty;
  } window_stats_t;

  // DUT ports, all inputs known from time zero
  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr_i   = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata_i  = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic                 opcode_i     = OP_PUSH;
  logic [RTT_W-1:0]     rtt_sample_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [RTT_W-1:0]     tail_rtt_o;
  logic [RTT_W-1:0]     median_rtt_o;
  logic [RTT_W-1:0]     jitter_o;
  logic [COUNT_W-1:0]   sample_count_o;
  logic                 window_empty_o;

  // Handshake pressure, percent of idle cycles
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;

  // Run bookkeeping
  int unsigned   fail_count     = 0;
  int unsigned   items_sent     = 0;
  int unsigned   pushes_sent    = 0;
  int unsigned   queries_sent   = 0;
  int unsigned   stats_checked  = 0;
  window_stats_t pending_stats[$];

  // Shadow copy of the window and registers
  logic [RTT_W-1:0] ring_m [WINDOW_DEPTH];
  int unsigned      slot_m   = 0;
  int unsigned      held_m   = 0;
  logic [RTT_W-1:0] jitter_m = '0;
  logic [WLEN_W-1:0] wlen_m  = WLEN_RST;
  logic [PCT_W-1:0]  pct_m   = PCT_RST;
  logic [RTT_W-1:0]  dflt_m  = DFLT_RST;

  rtt_window_percentile_jitter #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .rtt_sample_i  (rtt_sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tail_rtt_o    (tail_rtt_o),
    .median_rtt_o  (median_rtt_o),
    .jitter_o      (jitter_o),
    .sample_count_o(sample_count_o),
    .window_empty_o(window_empty_o)
  );

  always #2 clk_i = ~clk_i;

  // Receiver stalls at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Window length as the block uses it: 0 acts as 1, above depth saturates
  function automatic int unsigned eff_window();
    if (wlen_m < 1) return 1;
    if (wlen_m > WINDOW_DEPTH) return WINDOW_DEPTH;
    return wlen_m;
  endfunction

  // Update the shadow window for one accepted beat; queue stats for a query
  task automatic predict_window_stats(input logic op, input logic [RTT_W-1:0] smp);
    logic [RTT_W-1:0] ranked [WINDOW_DEPTH];
    logic [RTT_W-1:0] v;
    logic [RTT_W-1:0] med;
    window_stats_t    st;
    int unsigned      n, slot, rank, i, j;
    longint unsigned  dev_sum;
    if (op == OP_PUSH) begin
      ring_m[slot_m] = smp;
      slot_m = (slot_m + 1 >= WINDOW_DEPTH) ? 0 : slot_m + 1;
      if (held_m < eff_window()) held_m++;
      else held_m = eff_window();
      pushes_sent++;
    end else begin
      n = held_m;
      if (n == 0) begin
        st.tail   = dflt_m;
        st.median = dflt_m;
        st.jitter = jitter_m;
        st.count  = '0;
        st.empty  = 1'b1;
      end else begin
        // newest n samples, then insertion sort ascending
        slot = slot_m;
        for (i = 0; i < n; i++) begin
          slot = (slot == 0) ? WINDOW_DEPTH - 1 : slot - 1;
          ranked[i] = ring_m[slot];
        end
        for (i = 1; i < n; i++) begin
          v = ranked[i];
          j = i;
          while (j > 0 && ranked[j-1] > v) begin
            ranked[j] = ranked[j-1];
            j--;
          end
          ranked[j] = v;
        end
        rank = (pct_m * n) / PCT_SCALE;
        if (rank > n - 1) rank = n - 1;
        med = ranked[n/2];
        if (n > 1) begin
          dev_sum = 0;
          for (i = 0; i < n; i++)
            dev_sum += (ranked[i] >= med) ? ranked[i] - med : med - ranked[i];
          jitter_m = RTT_W'(dev_sum / n);
        end
        st.tail   = ranked[rank];
        st.median = med;
        st.jitter = jitter_m;
        st.count  = n[COUNT_W-1:0];
        st.empty  = 1'b0;
      end
      pending_stats.insert(pending_stats.size(), st);
      queries_sent++;
    end
  endtask

  // Send one input beat, idling first at the sender's rate
  task automatic send_beat(input logic op, input logic [RTT_W-1:0] smp);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    rtt_sample_i <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    predict_window_stats(op, smp);
  endtask

  // Drop valid, wait for every pending result, then let pushes finish
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write; the shadow registers follow at the same edge
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_WINDOW_LEN: begin
        wlen_m = data[WLEN_W-1:0];
        if (held_m > eff_window()) held_m = eff_window();
      end
      CFG_PERCENTILE:    pct_m  = data[PCT_W-1:0];
      CFG_EMPTY_DEFAULT: dflt_m = data[RTT_W-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sample values: small values give ties, near-max values stress the sums
  function automatic logic [RTT_W-1:0] rand_rtt();
    case ($urandom_range(0, 5))
      0:       return RTT_W'($urandom_range(0, 15));
      1:       return {RTT_W{1'b1}} - RTT_W'($urandom_range(0, 15));
      2:       return RTT_W'($urandom_range(1000, 200000));
      default: return RTT_W'($urandom());
    endcase
  endfunction

  // Check each result beat against the oldest prediction
  always @(posedge clk_i) begin : check_results
    window_stats_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_stats.size() == 0) begin
        $error("result beat with no query pending");
        fail_count++;
      end else begin
        want = pending_stats[0];
        pending_stats.delete(0);
        stats_checked++;
        if (tail_rtt_o !== want.tail) begin
          $error("tail_rtt: expected %0d, got %0d", want.tail, tail_rtt_o);
          fail_count++;
        end
        if (median_rtt_o !== want.median) begin
          $error("median_rtt: expected %0d, got %0d", want.median, median_rtt_o);
          fail_count++;
        end
        if (jitter_o !== want.jitter) begin
          $error("jitter: expected %0d, got %0d", want.jitter, jitter_o);
          fail_count++;
        end
        if (sample_count_o !== want.count) begin
          $error("sample_count: expected %0d, got %0d", want.count, sample_count_o);
          fail_count++;
        end
        if (window_empty_o !== want.empty) begin
          $error("window_empty: expected %0d, got %0d", want.empty, window_empty_o);
          fail_count++;
        end
      end
    end
  end

  // Empty window: defaults at reset value and at both extremes
  task automatic test_empty_window();
    send_beat(OP_QUERY, RTT_W'($urandom()));
    settle_block();
    write_register(CFG_EMPTY_DEFAULT, {CFG_DAT_W{1'b1}});
    send_beat(OP_QUERY, RTT_W'($urandom()));
    settle_block();
    write_register(CFG_EMPTY_DEFAULT, '0);
    send_beat(OP_QUERY, RTT_W'($urandom()));
    settle_block();
    write_register(CFG_EMPTY_DEFAULT, DFLT_RST);
  endtask

  // One sample held: jitter keeps its previous value
  task automatic test_single_sample();
    send_beat(OP_PUSH, 24'd1234);
    send_beat(OP_QUERY, '0);
  endtask

  // Sample extremes side by side
  task automatic test_extremes();
    send_beat(OP_PUSH, '0);
    send_beat(OP_PUSH, {RTT_W{1'b1}});
    send_beat(OP_QUERY, '0);
    send_beat(OP_PUSH, {RTT_W{1'b1}});
    send_beat(OP_QUERY, {RTT_W{1'b1}});
  endtask

  // Percentile at 0, 99 and above 99 where the rank saturates
  task automatic test_percentile_edges();
    settle_block();
    write_register(CFG_PERCENTILE, '0);
    send_beat(OP_QUERY, '0);
    settle_block();
    write_register(CFG_PERCENTILE, 24'd99);
    send_beat(OP_QUERY, '0);
    settle_block();
    write_register(CFG_PERCENTILE, 24'd100);
    send_beat(OP_QUERY, '0);
    settle_block();
    write_register(CFG_PERCENTILE, {CFG_DAT_W{1'b1}});
    send_beat(OP_QUERY, '0);
  endtask

  // Shrink below the held count, zero length, then grow again
  task automatic test_window_resize();
    int unsigned k;
    for (k = 0; k < 4; k++) send_beat(OP_PUSH, rand_rtt());
    settle_block();
    write_register(CFG_WINDOW_LEN, 24'd2);
    send_beat(OP_QUERY, '0);
    settle_block();
    write_register(CFG_WINDOW_LEN, '0);
    send_beat(OP_QUERY, '0);
    send_beat(OP_PUSH, rand_rtt());
    send_beat(OP_QUERY, '0);
    settle_block();
    write_register(CFG_WINDOW_LEN, 24'd8);
    send_beat(OP_PUSH, rand_rtt());
    send_beat(OP_PUSH, rand_rtt());
    send_beat(OP_QUERY, '0);
  endtask

  // Window over depth saturates, then exactly full at depth
  task automatic test_full_window();
    int unsigned k;
    settle_block();
    write_register(CFG_WINDOW_LEN, {CFG_DAT_W{1'b1}});
    write_register(CFG_PERCENTILE, CFG_DAT_W'($urandom_range(0, 99)));
    for (k = 0; k < WINDOW_DEPTH + 6; k++) send_beat(OP_PUSH, rand_rtt());
    send_beat(OP_QUERY, RTT_W'($urandom()));
    settle_block();
    write_register(CFG_WINDOW_LEN, CFG_DAT_W'(WINDOW_DEPTH));
    write_register(CFG_PERCENTILE, {CFG_DAT_W{1'b1}});
    send_beat(OP_PUSH, rand_rtt());
    send_beat(OP_QUERY, RTT_W'($urandom()));
  endtask

  // Random bursts of pushes closed by a query, with random reconfiguration
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned stop_at, burst, k, pick;
    logic [WLEN_W-1:0] wl;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0) begin
        settle_block();
        pick = $urandom_range(0, 99);
        if (pick < 80)      wl = WLEN_W'($urandom_range(1, 16));
        else if (pick < 95) wl = WLEN_W'($urandom_range(17, 48));
        else case ($urandom_range(0, 3))
          0: wl = '0;
          1: wl = WLEN_W'(1);
          2: wl = WLEN_W'(WINDOW_DEPTH);
          default: wl = 8'hFF;
        endcase
        write_register(CFG_WINDOW_LEN, CFG_DAT_W'({$urandom_range(0, 16'hFFFF), wl}));
        if ($urandom_range(0, 1))
          write_register(CFG_PERCENTILE,
                         CFG_DAT_W'({$urandom_range(0, 17'h1FFFF),
                                     PCT_W'($urandom_range(0, 3) == 0
                                            ? $urandom_range(0, 127)
                                            : $urandom_range(0, 99))}));
        if ($urandom_range(0, 1))
          write_register(CFG_EMPTY_DEFAULT, CFG_DAT_W'($urandom()));
        if ($urandom_range(0, 7) == 0)
          write_register(CFG_UNUSED, CFG_DAT_W'($urandom()));
      end
      burst = $urandom_range(0, 2 * eff_window() + 2);
      if (burst > 48) burst = $urandom_range(0, 48) + (eff_window() > 48 ? 48 : 0);
      for (k = 0; k < burst; k++) send_beat(OP_PUSH, rand_rtt());
      send_beat(OP_QUERY, RTT_W'($urandom()));
      if ($urandom_range(0, 5) == 0) send_beat(OP_QUERY, RTT_W'($urandom()));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender 28 / receiver 49, then swapped, then no idling
    send_idle = 28;
    recv_idle = 49;
    test_empty_window();
    test_single_sample();
    test_extremes();
    test_percentile_edges();
    test_window_resize();
    test_random_traffic(420);
    test_full_window();

    settle_block();
    send_idle = 49;
    recv_idle = 28;
    test_random_traffic(420);
    test_full_window();

    settle_block();
    send_idle = 0;
    recv_idle = 0;
    test_random_traffic(420);
    test_full_window();

    settle_block();
    $display("Covered %0d pushes and %0d queries (%0d results checked) under three",
             pushes_sent, queries_sent, stats_checked);
    $display("handshake pressure settings, window lengths 0..255, percentiles 0..127.");
    if (fail_count == 0) begin
      $display("rtt_window_percentile_jitter test passed");
    end else begin
      $display("rtt_window_percentile_jitter test failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #400_000_000;
    $display("rtt_window_percentile_jitter test failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/rttwpj_pkg.sv
rtl/rtt_window_percentile_jitter.sv
tb/sv/tb_rtt_window_percentile_jitter.sv
